// File: rtl/crrf_pkg.sv
// ----------------------------------------------------------------------------
// crrf_pkg
// Shared types and constants for the clipped rounded-rectangle fill engine.
// ----------------------------------------------------------------------------
package crrf_pkg;

    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 240;
    localparam int CW = 10;           // coordinate width
    localparam int RW = 9;            // radius width
    localparam int PW = 16;           // pixel width
    localparam int QDEPTH = 2;        // command queue depth
    localparam int QAW = 1;           // queue address width

    // Clip register indexes on the configuration port.
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_TOP    = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    typedef enum logic [1:0] {
        OP_FILL  = 2'd0,
        OP_ROUND = 2'd1,
        OP_PLOT  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Command as classified by the front end.
    typedef struct packed {
        op_t                    op;
        logic signed [CW+1:0]   x;
        logic signed [CW+1:0]   y;
        logic signed [CW+1:0]   w;
        logic signed [CW+1:0]   h;
        logic signed [RW:0]     r;    // clamped radius, 0 means plain fill
        logic [PW-1:0]          colour;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ISET,
        ST_ISTEP,
        ST_SPAN,
        ST_READ
    } bst_t;

endpackage

// File: rtl/crrf_front.sv
// ----------------------------------------------------------------------------
// crrf_front
// Accepts commands, clamps the corner radius and pushes the command queue.
// ----------------------------------------------------------------------------
module crrf_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          op,
    input  logic signed [crrf_pkg::CW-1:0]      pos_x,
    input  logic signed [crrf_pkg::CW-1:0]      pos_y,
    input  logic signed [crrf_pkg::CW-1:0]      size_w,
    input  logic signed [crrf_pkg::CW-1:0]      size_h,
    input  logic signed [crrf_pkg::RW-1:0]      radius,
    input  logic [crrf_pkg::PW-1:0]             colour,
    input  logic                                pop,
    output logic                                q_valid,
    output crrf_pkg::cmd_t                      q_head
);

    crrf_pkg::cmd_t              mem_reg [crrf_pkg::QDEPTH];
    logic [crrf_pkg::QAW-1:0]    wp_reg, rp_reg;
    logic [crrf_pkg::QAW:0]      cnt_reg;
    crrf_pkg::cmd_t              cmd;
    logic signed [crrf_pkg::CW-1:0] lim;
    logic                        push;

    assign busy    = (cnt_reg == (crrf_pkg::QAW+1)'(crrf_pkg::QDEPTH));
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != '0);
    assign q_head  = mem_reg[rp_reg];

    always_comb
    begin
        // half of the smaller side, rounded down (toward zero for positive sides)
        lim = ((size_w < size_h) ? size_w : size_h) >>> 1;
        cmd.op     = crrf_pkg::op_t'(op);
        cmd.x      = (crrf_pkg::CW+2)'(pos_x);
        cmd.y      = (crrf_pkg::CW+2)'(pos_y);
        cmd.w      = (crrf_pkg::CW+2)'(size_w);
        cmd.h      = (crrf_pkg::CW+2)'(size_h);
        cmd.colour = colour;
        if ((crrf_pkg::CW)'(radius) > lim)
            cmd.r = (crrf_pkg::RW+1)'(lim);
        else
            cmd.r = (crrf_pkg::RW+1)'(radius);
        if (cmd.r[crrf_pkg::RW])
            cmd.r = '0;   // negative radius: plain fill
        if (size_w <= 0 || size_h <= 0)
            cmd.w = '0;   // empty: nothing drawn
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (crrf_pkg::QAW+1)'(push) - (crrf_pkg::QAW+1)'(pop);
        end
    end

endmodule

// File: rtl/crrf_back.sv
// ----------------------------------------------------------------------------
// crrf_back
// Executes queued commands: span walker, inset search and frame memory.
// ----------------------------------------------------------------------------
module crrf_back
#(
    parameter int SCREEN_WIDTH  = crrf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = crrf_pkg::DEF_SCREEN_HEIGHT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  crrf_pkg::cmd_t                      q_head,
    output logic                                pop,
    input  logic signed [crrf_pkg::CW+1:0]      wx0,
    input  logic signed [crrf_pkg::CW+1:0]      wy0,
    input  logic signed [crrf_pkg::CW+1:0]      wx1,
    input  logic signed [crrf_pkg::CW+1:0]      wy1,
    output logic                                done,
    output logic [crrf_pkg::PW-1:0]             read_data
);

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = crrf_pkg::CW + 2;

    typedef logic signed [SW-1:0] s_t;

    logic [crrf_pkg::PW-1:0] mem [DEPTH];

    crrf_pkg::bst_t state_reg, state_next;
    crrf_pkg::cmd_t cmd_reg, cmd_next;
    // phase: 0 slab, then cap rows dy=0..r-1 top and bottom
    s_t   row_reg, row_next;      // current row
    s_t   yend_reg, yend_next;    // last row+1 of slab
    s_t   xc_reg, xc_next;        // current column
    s_t   xe_reg, xe_next;        // end column
    logic [crrf_pkg::RW-1:0] dy_reg, dy_next;
    logic [crrf_pkg::RW-1:0] dx_reg, dx_next;
    logic                    bot_reg, bot_next;   // bottom cap row pending
    logic                    cap_reg, cap_next;   // in cap rows
    logic [2*crrf_pkg::RW+1:0] rr_reg, rr_next;   // r*r - v*v
    logic [2*crrf_pkg::RW+1:0] sq;

    logic                    we;
    logic [AW-1:0]           waddr, raddr;
    logic [AW+1:0]           addr_full;
    logic                    rd_pend_reg, rd_pend_next;
    logic                    rd_ok_reg;
    logic [crrf_pkg::PW-1:0] rdat_reg;
    s_t                      inset, cx0, cx1, ry, rx;

    always_comb
    begin
        addr_full = (AW+2)'(ry) * (AW+2)'(SCREEN_WIDTH) + (AW+2)'(rx);
    end

    assign waddr = addr_full[AW-1:0];
    assign raddr = addr_full[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= cmd_reg.colour;
        rdat_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        row_next     = row_reg;
        yend_next    = yend_reg;
        xc_next      = xc_reg;
        xe_next      = xe_reg;
        dy_next      = dy_reg;
        dx_next      = dx_reg;
        bot_next     = bot_reg;
        cap_next     = cap_reg;
        rr_next      = rr_reg;
        rd_pend_next = 1'b0;
        pop          = 1'b0;
        we           = 1'b0;
        ry           = row_reg;
        rx           = xc_reg;
        sq           = (2*crrf_pkg::RW+2)'(dx_reg + 1'b1) * (2*crrf_pkg::RW+2)'(dx_reg + 1'b1);
        inset        = s_t'(cmd_reg.r) - s_t'(dx_reg);
        cx0          = '0;
        cx1          = '0;
        unique case (state_reg)
            crrf_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop      = 1'b1;
                    cmd_next = q_head;
                    cap_next = 1'b0;
                    unique case (q_head.op)
                        crrf_pkg::OP_READ:  state_next = crrf_pkg::ST_READ;
                        crrf_pkg::OP_PLOT:
                        begin
                            cmd_next.w = s_t'(1);
                            cmd_next.h = s_t'(1);
                            cmd_next.r = '0;
                            state_next = crrf_pkg::ST_SETUP;
                        end
                        crrf_pkg::OP_FILL:
                        begin
                            cmd_next.r = '0;
                            state_next = crrf_pkg::ST_SETUP;
                        end
                        default:
                        begin
                            if (q_head.w <= 0)
                                state_next = crrf_pkg::ST_IDLE;
                            else
                                state_next = crrf_pkg::ST_SETUP;
                        end
                    endcase
                end
            end
            crrf_pkg::ST_SETUP:
            begin
                // the slab covers rows y+r .. y+h-r-1 at full width
                cx0 = (cmd_reg.x < wx0) ? wx0 : cmd_reg.x;
                cx1 = (cmd_reg.x + cmd_reg.w > wx1) ? wx1 : cmd_reg.x + cmd_reg.w;
                row_next  = cmd_reg.y + s_t'(cmd_reg.r);
                yend_next = cmd_reg.y + cmd_reg.h - s_t'(cmd_reg.r);
                if (row_next < wy0)
                    row_next = wy0;
                if (yend_next > wy1)
                    yend_next = wy1;
                xc_next = cx0;
                xe_next = cx1;
                if (cx0 < cx1 && row_next < yend_next)
                    state_next = crrf_pkg::ST_SPAN;
                else
                    state_next = crrf_pkg::ST_ISET;
                dy_next  = '0;
                cap_next = 1'b0;
            end
            crrf_pkg::ST_SPAN:
            begin
                we      = 1'b1;
                xc_next = xc_reg + 1'b1;
                if (xc_next >= xe_reg)
                begin
                    xc_next = cx0;
                    if (cap_reg)
                    begin
                        state_next = bot_reg ? crrf_pkg::ST_ISET : crrf_pkg::ST_ISET;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        xc_next  = (cmd_reg.x < wx0) ? wx0 : cmd_reg.x;
                        if (row_next >= yend_reg)
                            state_next = crrf_pkg::ST_ISET;
                    end
                end
            end
            crrf_pkg::ST_ISET:
            begin
                // bottom row of the current cap pair, else next pair's search, or finish
                if (cap_reg && bot_reg)
                begin
                    bot_next   = 1'b0;
                    row_next   = cmd_reg.y + cmd_reg.h - 1'b1 - s_t'(dy_reg);
                    cx0 = cmd_reg.x + inset;
                    cx1 = cmd_reg.x + cmd_reg.w - inset;
                    if (cx0 < wx0) cx0 = wx0;
                    if (cx1 > wx1) cx1 = wx1;
                    xc_next = cx0;
                    xe_next = cx1;
                    dy_next = dy_reg + 1'b1;
                    if (cx0 < cx1 && row_next >= wy0 && row_next < wy1)
                        state_next = crrf_pkg::ST_SPAN;
                end
                else if (s_t'(dy_reg) >= s_t'(cmd_reg.r))
                    state_next = crrf_pkg::ST_IDLE;
                else
                begin
                    dx_next  = '0;
                    rr_next  = (2*crrf_pkg::RW+2)'(cmd_reg.r) * (2*crrf_pkg::RW+2)'(cmd_reg.r)
                             - (2*crrf_pkg::RW+2)'(s_t'(cmd_reg.r) - s_t'(dy_reg))
                             * (2*crrf_pkg::RW+2)'(s_t'(cmd_reg.r) - s_t'(dy_reg));
                    state_next = crrf_pkg::ST_ISTEP;
                end
            end
            crrf_pkg::ST_ISTEP:
            begin
                if (sq <= rr_reg)
                    dx_next = dx_reg + 1'b1;
                else
                begin
                    cap_next = 1'b1;
                    bot_next = 1'b1;
                    row_next = cmd_reg.y + s_t'(dy_reg);
                    cx0 = cmd_reg.x + inset;
                    cx1 = cmd_reg.x + cmd_reg.w - inset;
                    if (cx0 < wx0) cx0 = wx0;
                    if (cx1 > wx1) cx1 = wx1;
                    xc_next = cx0;
                    xe_next = cx1;
                    if (cx0 < cx1 && row_next >= wy0 && row_next < wy1)
                        state_next = crrf_pkg::ST_SPAN;
                    else
                        state_next = crrf_pkg::ST_ISET;
                end
            end
            crrf_pkg::ST_READ:
            begin
                ry = cmd_reg.y;
                rx = cmd_reg.x;
                rd_pend_next = 1'b1;
                state_next   = crrf_pkg::ST_IDLE;
            end
            default: state_next = crrf_pkg::ST_IDLE;
        endcase
        if (state_reg == crrf_pkg::ST_SPAN && cap_reg)
            cx0 = xc_reg;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        row_reg  <= row_next;
        yend_reg <= yend_next;
        xc_reg   <= xc_next;
        xe_reg   <= xe_next;
        dy_reg   <= dy_next;
        dx_reg   <= dx_next;
        rr_reg   <= rr_next;
        bot_reg  <= bot_next;
        rd_ok_reg <= cmd_reg.x >= 0 && cmd_reg.x < s_t'(SCREEN_WIDTH)
                  && cmd_reg.y >= 0 && cmd_reg.y < s_t'(SCREEN_HEIGHT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= crrf_pkg::ST_IDLE;
            cap_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    assign done      = rd_pend_reg;
    assign read_data = rd_ok_reg ? rdat_reg : '0;

endmodule

// File: rtl/clipped_round_rect_fill_core.sv
// ----------------------------------------------------------------------------
// clipped_round_rect_fill_core
// RGB565 frame engine: rectangle fill, rounded fill, plot and pixel read.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers when start is high and busy is low. Fields op, pos_x,
//   pos_y, size_w, size_h, radius and colour are sampled at that edge.
//   A front stage clamps the radius and pushes a two-entry command queue;
//   busy is high only while that queue is full.
//   The back end writes one pixel per cycle inside the clip window while it
//   walks a span. A fill walks its clipped rows span by span; a rounded
//   fill adds per cap row the inset search plus its two clipped spans.
//   A read on an idle engine passes the queue, ST_IDLE and ST_READ; done then
//   rises with read_data valid (0 off screen). The receiver cannot stall.
//   The user must write the clip registers via cfg_we/cfg_index/cfg_data only
//   while idle (not enforced); the window registers follow in the next cycle.
//   Reset clears control and sets the window to the full screen; the frame
//   memory is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module clipped_round_rect_fill_core
#(
    parameter int SCREEN_WIDTH  = crrf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = crrf_pkg::DEF_SCREEN_HEIGHT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          op,
    input  logic signed [crrf_pkg::CW-1:0]      pos_x,
    input  logic signed [crrf_pkg::CW-1:0]      pos_y,
    input  logic signed [crrf_pkg::CW-1:0]      size_w,
    input  logic signed [crrf_pkg::CW-1:0]      size_h,
    input  logic signed [crrf_pkg::RW-1:0]      radius,
    input  logic [crrf_pkg::PW-1:0]             colour,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [crrf_pkg::CW-1:0]             cfg_data,
    output logic                                done,
    output logic [crrf_pkg::PW-1:0]             read_data
);

    localparam int SW = crrf_pkg::CW + 2;
    typedef logic signed [SW-1:0] s_t;

    logic signed [crrf_pkg::CW-1:0] cl_reg, ct_reg, cw_reg, ch_reg;
    s_t wx0_reg, wy0_reg, wx1_reg, wy1_reg;
    s_t rgt, bot, x0, y0, x1, y1;

    logic           pop, q_valid;
    crrf_pkg::cmd_t q_head;

    // clip register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cl_reg <= '0;
            ct_reg <= '0;
            cw_reg <= crrf_pkg::CW'(SCREEN_WIDTH);
            ch_reg <= crrf_pkg::CW'(SCREEN_HEIGHT);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crrf_pkg::REG_LEFT:   cl_reg <= cfg_data;
                crrf_pkg::REG_TOP:    ct_reg <= cfg_data;
                crrf_pkg::REG_WIDTH:  cw_reg <= cfg_data;
                crrf_pkg::REG_HEIGHT: ch_reg <= cfg_data;
            endcase
        end
    end

    // effective window, clamped to the screen
    always_comb
    begin
        rgt = s_t'(cl_reg) + s_t'(cw_reg);
        bot = s_t'(ct_reg) + s_t'(ch_reg);
        x0  = (cl_reg < 0) ? '0 : s_t'(cl_reg);
        y0  = (ct_reg < 0) ? '0 : s_t'(ct_reg);
        x1  = (rgt > s_t'(SCREEN_WIDTH)) ? s_t'(SCREEN_WIDTH) : rgt;
        y1  = (bot > s_t'(SCREEN_HEIGHT)) ? s_t'(SCREEN_HEIGHT) : bot;
        if (x1 < x0) x1 = x0;
        if (y1 < y0) y1 = y0;
    end

    always_ff @(posedge clk)
    begin
        wx0_reg <= x0;
        wy0_reg <= y0;
        wx1_reg <= x1;
        wy1_reg <= y1;
    end

    crrf_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .op      (op),
        .pos_x   (pos_x),
        .pos_y   (pos_y),
        .size_w  (size_w),
        .size_h  (size_h),
        .radius  (radius),
        .colour  (colour),
        .pop     (pop),
        .q_valid (q_valid),
        .q_head  (q_head)
    );

    crrf_back
    #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (pop),
        .wx0       (wx0_reg),
        .wy0       (wy0_reg),
        .wx1       (wx1_reg),
        .wy1       (wy1_reg),
        .done      (done),
        .read_data (read_data)
    );

endmodule
